// ===== hw/rtl/efsa_pkg.sv =====
// Package with shared types and constants for the edge force scatter-accumulate block.
`timescale 1ns / 1ps
package efsa_pkg;
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam int   NODE_W   = 10;
  localparam int   VAL_W    = 32;

  typedef logic signed [VAL_W-1:0] q_t;
  typedef logic signed [49:0]      wide_t;

  typedef struct packed {
    q_t fx;
    q_t fy;
    q_t fz;
  } force_t;

  function automatic q_t sat32(input logic signed [51:0] x);
    if (x > 52'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (x < -52'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction
endpackage

// ===== hw/rtl/efsa_div3.sv =====
// Pipelined signed divide by three with truncation toward zero and saturation to 32 bits.
`timescale 1ns / 1ps
module efsa_div3 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [49:0]   dividend,
  output logic                 done,
  output efsa_pkg::q_t         quotient
);
  import efsa_pkg::*;

  localparam logic [17:0] RCP_HI = 18'd174763;
  localparam logic [18:0] RCP_LO = 19'd349526;

  logic        va_r, vb_r, done_r;
  logic        neg_a_r, big_a_r;
  logic [32:0] mag_a_r;
  logic        neg_b_r, big_b_r;
  logic [15:0] qh_b_r;
  logic [1:0]  rh_b_r;
  logic [15:0] lo_b_r;
  q_t          quo_r;
  logic [49:0] mag;
  logic [34:0] hi_prod;
  logic [15:0] qh;
  logic [16:0] qh3;
  logic [1:0]  rh;
  logic [17:0] lo_num;
  logic [36:0] lo_prod;
  logic [15:0] ql;
  logic [31:0] qmag;
  logic signed [51:0] sq;

  assign mag = dividend[49] ? 50'(-dividend) : dividend;

  assign hi_prod = mag_a_r[32:16] * RCP_HI;
  assign qh      = 16'(hi_prod >> 19);
  assign qh3     = 17'(qh) * 17'd3;
  assign rh      = 2'(mag_a_r[32:16] - qh3);

  assign lo_num  = {rh_b_r, lo_b_r};
  assign lo_prod = lo_num * RCP_LO;
  assign ql      = 16'(lo_prod >> 20);
  assign qmag    = {qh_b_r, ql};
  assign sq = neg_b_r ? -$signed({20'd0, qmag}) : $signed({20'd0, qmag});

  always_ff @(posedge clk) begin
    if (start) begin
      neg_a_r <= dividend[49];
      big_a_r <= |mag[49:33];
      mag_a_r <= mag[32:0];
    end
    if (va_r) begin
      neg_b_r <= neg_a_r;
      big_b_r <= big_a_r;
      qh_b_r  <= qh;
      rh_b_r  <= rh;
      lo_b_r  <= mag_a_r[15:0];
    end
    if (vb_r) begin
      if (big_b_r) begin
        quo_r <= neg_b_r ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        quo_r <= sat32(sq);
      end
    end
    if (!rst_n) begin
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      va_r   <= start;
      vb_r   <= va_r;
      done_r <= vb_r;
    end
  end

  assign done = done_r;
  assign quotient = quo_r;
endmodule

// ===== hw/rtl/efsa_store.sv =====
// Force store memory with registered read and a clearing sweep after reset.
`timescale 1ns / 1ps
module efsa_store #(
  parameter int NODES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(NODES)-1:0]      rd_addr,
  output efsa_pkg::force_t              rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(NODES)-1:0]      wr_addr,
  input  efsa_pkg::force_t              wr_data,
  output logic                          clearing
);
  import efsa_pkg::*;
  localparam int AW = $clog2(NODES);

  force_t           mem [NODES];
  logic [AW:0]      clr_r;

  assign clearing = !clr_r[AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (clearing) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r[AW-1:0] == AW'(NODES - 1)) begin
        clr_r <= {1'b1, {AW{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_r[AW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== hw/rtl/edge_force_scatter_accumulate.sv =====
// Top level of the edge force scatter-accumulate block.
`timescale 1ns / 1ps
// A read passes through S_RDW and S_RDO: out_valid is strobed as busy drops. An edge
// steps through products, sums, two coefficient divides by three through a three-stage
// reciprocal pipeline, the r products and sums, then a read-modify-write of the column
// node and then of the row node in the force memory; the row read waits for the column
// write so a self edge sees the updated force. After reset the store is swept to zero,
// one node per cycle, with busy high. out_valid is a one-cycle strobe; the receiver
// cannot stall it.
module edge_force_scatter_accumulate #(
  parameter int NODES = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic [9:0]               in_row_node,
  input  logic [9:0]               in_col_node,
  input  logic signed [31:0]       in_edge_weight,
  input  logic signed [31:0]       in_row_vx,
  input  logic signed [31:0]       in_row_vy,
  input  logic signed [31:0]       in_row_vz,
  input  logic signed [31:0]       in_col_vx,
  input  logic signed [31:0]       in_col_vy,
  input  logic signed [31:0]       in_col_vz,
  output logic                     out_valid,
  output logic signed [31:0]       out_force_x,
  output logic signed [31:0]       out_force_y,
  output logic signed [31:0]       out_force_z
);
  import efsa_pkg::*;
  localparam int AW = $clog2(NODES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDW   = 4'd1;
  localparam logic [3:0] S_RDO   = 4'd2;
  localparam logic [3:0] S_PM    = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_DIV0  = 4'd5;
  localparam logic [3:0] S_DIV1  = 4'd6;
  localparam logic [3:0] S_RP    = 4'd7;
  localparam logic [3:0] S_RSUM  = 4'd8;
  localparam logic [3:0] S_CRD   = 4'd9;
  localparam logic [3:0] S_CWR   = 4'd10;
  localparam logic [3:0] S_RRD   = 4'd11;
  localparam logic [3:0] S_RWR   = 4'd12;
  localparam logic [3:0] S_D0GO  = 4'd13;

  logic [3:0]  st_r;
  logic [9:0]  row_r, col_r;
  q_t          w_r;
  q_t          vi_r [3];
  q_t          vj_r [3];
  logic signed [63:0] p_r [6];
  wide_t       s0_r, s1_r;
  q_t          a0_r;
  q_t          a1_r;
  logic signed [50:0] r_r [3];
  logic        div_start;
  wide_t       div_in;
  logic        div_done;
  q_t          div_q;
  logic [AW-1:0] rd_addr;
  force_t      rd_data;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  force_t      wr_data;
  logic        clearing;
  logic        out_valid_r;
  force_t      out_r;
  logic        rd_ok_r;

  efsa_div3 u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_in),
    .done(div_done), .quotient(div_q)
  );

  efsa_store #(.NODES(NODES)) u_store (
    .clk(clk), .rst_n(rst_n), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .clearing(clearing)
  );

  function automatic wide_t fs16(input logic signed [63:0] p);
    fs16 = wide_t'(p >>> 16);
  endfunction

  function automatic q_t upd(input q_t old, input logic signed [50:0] r, input logic sub);
    logic signed [51:0] o;
    o = 52'(old);
    upd = sub ? sat32(o - 52'(r)) : sat32(o + 52'(r));
  endfunction

  assign busy = (st_r != S_IDLE) || clearing;
  assign div_start = (st_r == S_D0GO) || (st_r == S_DIV0 && div_done);
  assign div_in = (st_r == S_D0GO) ? s0_r : s1_r;
  assign rd_addr = (st_r == S_IDLE) ? AW'(in_row_node)
                 : (st_r == S_CRD) ? AW'(col_r) : AW'(row_r);
  assign wr_en = (st_r == S_CWR && {22'd0, col_r} < 32'(NODES)) ||
                 (st_r == S_RWR && {22'd0, row_r} < 32'(NODES));
  assign wr_addr = (st_r == S_CWR) ? AW'(col_r) : AW'(row_r);
  assign wr_data.fx = upd(rd_data.fx, r_r[0], st_r == S_CWR);
  assign wr_data.fy = upd(rd_data.fy, r_r[1], st_r == S_CWR);
  assign wr_data.fz = upd(rd_data.fz, r_r[2], st_r == S_CWR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start && !clearing) begin
            row_r <= in_row_node;
            col_r <= in_col_node;
            w_r   <= in_edge_weight;
            vi_r[0] <= in_row_vx; vi_r[1] <= in_row_vy; vi_r[2] <= in_row_vz;
            vj_r[0] <= in_col_vx; vj_r[1] <= in_col_vy; vj_r[2] <= in_col_vz;
            rd_ok_r <= {22'd0, in_row_node} < 32'(NODES);
            st_r <= (in_command == CMD_READ) ? S_RDW : S_PM;
          end
        end
        S_RDW: st_r <= S_RDO;
        S_RDO: begin
          out_r <= rd_ok_r ? rd_data : '0;
          out_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_PM: begin
          for (int k = 0; k < 3; k++) begin
            p_r[k]   <= 64'(w_r) * 64'(vi_r[k]);
            p_r[k+3] <= 64'(w_r) * 64'(vj_r[k]);
          end
          st_r <= S_SUM;
        end
        S_SUM: begin
          s0_r <= fs16(p_r[0]) + fs16(p_r[1]) + fs16(p_r[2]);
          s1_r <= fs16(p_r[3]) + fs16(p_r[4]) + fs16(p_r[5]);
          st_r <= S_D0GO;
        end
        S_D0GO: st_r <= S_DIV0;
        S_DIV0: begin
          if (div_done) begin
            a0_r <= div_q;
            st_r <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            a1_r <= div_q;
            st_r <= S_RP;
          end
        end
        S_RP: begin
          for (int k = 0; k < 3; k++) begin
            p_r[k]   <= 64'(a0_r) * 64'(vi_r[k]);
            p_r[k+3] <= 64'(a1_r) * 64'(vj_r[k]);
          end
          st_r <= S_RSUM;
        end
        S_RSUM: begin
          for (int k = 0; k < 3; k++) begin
            r_r[k] <= 51'(fs16(p_r[k])) + 51'(fs16(p_r[k+3])) + 51'(w_r);
          end
          st_r <= S_CRD;
        end
        S_CRD: st_r <= S_CWR;
        S_CWR: st_r <= S_RRD;
        S_RRD: st_r <= S_RWR;
        S_RWR: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_force_x = out_r.fx;
  assign out_force_y = out_r.fy;
  assign out_force_z = out_r.fz;

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !clearing) else $error("result during clear");
  a_write_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (st_r == S_CWR || st_r == S_RWR)) else $error("stray write");
  a_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r) == S_RDO) else $error("stray strobe");
endmodule
